@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/ccnt_pkg.sv @@
// Package: types, constants and character helpers for the formula token counter
`timescale 1ns / 1ps

package ccnt_pkg;

    localparam int TABLE_DEPTH = 16;

    typedef struct packed {
        logic [7:0] ch;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic [15:0] symbol_code;
        logic [15:0] atom_count;
        logic        table_overflow;
        logic        last_entry;
    } t_out_word;

    typedef struct packed {
        logic        valid;
        logic [15:0] sym;
        logic [15:0] total;
    } t_entry;

    typedef struct packed {
        logic        commit;
        logic        drain;
        logic [15:0] sym;
        logic [15:0] add;
    } t_row_ctl;

    typedef struct packed {
        logic        commit;
        logic        insert_ok;
        logic        drain;
        logic [15:0] sym;
        logic [15:0] add;
    } t_cell_ctl;

    typedef struct packed {
        logic   any_match;
        logic   full;
        t_entry head;
        logic   second_valid;
    } t_row_stat;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_SYM   = 3'b010,
        PH_NUM   = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_FINAL = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_J = 8'h4A;
    localparam logic [7:0] CH_UP_Q = 8'h51;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_J = 8'h6A;
    localparam logic [7:0] CH_LO_Q = 8'h71;
    localparam logic [7:0] CH_LO_U = 8'h75;
    localparam logic [7:0] CH_LO_Y = 8'h79;
    localparam logic [7:0] CH_D0   = 8'h30;
    localparam logic [7:0] CH_D9   = 8'h39;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CH_UP_A) && (c <= CH_UP_Z) && (c != CH_UP_J) && (c != CH_UP_Q);
    endfunction

    // a..u without j and q, plus y
    function automatic logic is_lower(input logic [7:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_U) && (c != CH_LO_J) && (c != CH_LO_Q))
            || (c == CH_LO_Y);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_D0) && (c <= CH_D9);
    endfunction

    // coeff * 10 + digit, saturating
    function automatic logic [15:0] add_digit(input logic [15:0] coeff, input logic [7:0] c);
        logic [19:0] v;
        v = ({4'b0, coeff} << 3) + ({4'b0, coeff} << 1) + {16'b0, c[3:0]};
        return (v[19:16] != 4'b0) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

@@ rtl/chemical_formula_token_counter_core.sv @@
// Top level: character tokeniser, sorted count row and result output register
//
//  channel  | valid   | stall   | word
//  ---------+---------+---------+---------------------------
//  input    | i_valid | o_stall | i_data (ch, last_char)
//  output   | o_valid | i_stall | o_data (symbol, count, flags)
//
// One character per cycle while tokenising. The block commits the last token in the
// cycle after the final character, then emits one entry per cycle from the head of
// the cell row, up to TABLE_DEPTH entries; input is stalled meanwhile.
// Output stall holds the result register and pauses the drain.
// Synchronous active-low reset empties the row and returns to tokenising.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chemical_formula_token_counter_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ccnt_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output ccnt_pkg::t_out_word o_data
);

    ccnt_pkg::t_state    r_state;
    ccnt_pkg::t_state    n_state;
    ccnt_pkg::t_phase    r_phase;
    ccnt_pkg::t_phase    n_phase;
    logic [15:0]         r_sym;
    logic [15:0]         n_sym;
    logic [15:0]         r_coeff;
    logic [15:0]         n_coeff;
    logic                r_digits;
    logic                n_digits;
    logic                r_overflow;
    logic                n_overflow;
    logic                r_out_valid;
    logic                n_out_valid;
    ccnt_pkg::t_out_word r_out;
    ccnt_pkg::t_out_word n_out;

    logic                w_accept;
    logic                w_commit_now;
    logic                w_load;
    ccnt_pkg::t_row_ctl  w_ctl;
    ccnt_pkg::t_row_stat w_stat;

    assign o_stall  = (r_state != ccnt_pkg::ST_RUN);
    assign w_accept = i_valid && !o_stall;
    assign w_load   = (r_state == ccnt_pkg::ST_DRAIN) && (!r_out_valid || !i_stall);

    // tokeniser
    always_comb begin
        logic w_start;
        w_start      = 1'b0;
        w_commit_now = 1'b0;
        n_phase      = r_phase;
        n_sym        = r_sym;
        n_coeff      = r_coeff;
        n_digits     = r_digits;
        if (w_accept) begin
            case (r_phase)
                ccnt_pkg::PH_SYM: begin
                    if (ccnt_pkg::is_lower(i_data.ch)) begin
                        n_sym   = {r_sym[15:8], i_data.ch};
                        n_phase = ccnt_pkg::PH_NUM;
                    end else if (ccnt_pkg::is_digit(i_data.ch)) begin
                        n_coeff  = ccnt_pkg::add_digit(r_coeff, i_data.ch);
                        n_digits = 1'b1;
                        n_phase  = ccnt_pkg::PH_NUM;
                    end else begin
                        w_commit_now = 1'b1;
                        w_start      = 1'b1;
                    end
                end
                ccnt_pkg::PH_NUM: begin
                    if (ccnt_pkg::is_digit(i_data.ch)) begin
                        n_coeff  = ccnt_pkg::add_digit(r_coeff, i_data.ch);
                        n_digits = 1'b1;
                    end else begin
                        w_commit_now = 1'b1;
                        w_start      = 1'b1;
                    end
                end
                default: begin
                    w_start = 1'b1;
                end
            endcase
            if (w_start) begin
                n_coeff  = '0;
                n_digits = 1'b0;
                if (ccnt_pkg::is_upper(i_data.ch)) begin
                    n_sym   = {i_data.ch, 8'h00};
                    n_phase = ccnt_pkg::PH_SYM;
                end else begin
                    n_sym   = '0;
                    n_phase = ccnt_pkg::PH_NUM;
                end
            end
        end else if (r_state == ccnt_pkg::ST_FINAL) begin
            n_phase  = ccnt_pkg::PH_START;
            n_sym    = '0;
            n_coeff  = '0;
            n_digits = 1'b0;
        end
    end

    assign w_ctl = '{
        commit: (w_accept && w_commit_now) || (r_state == ccnt_pkg::ST_FINAL),
        drain:  w_load,
        sym:    r_sym,
        add:    r_digits ? r_coeff : 16'd1
    };

    ccnt_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat)
    );

    // sequencing and output register
    always_comb begin
        n_state     = r_state;
        n_overflow  = r_overflow || (w_ctl.commit && !w_stat.any_match && w_stat.full);
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        case (r_state)
            ccnt_pkg::ST_RUN: begin
                if (w_accept && i_data.last_char) begin
                    n_state = ccnt_pkg::ST_FINAL;
                end
            end
            ccnt_pkg::ST_FINAL: begin
                n_state = ccnt_pkg::ST_DRAIN;
            end
            ccnt_pkg::ST_DRAIN: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out       = '{
                        symbol_code:    w_stat.head.sym,
                        atom_count:     w_stat.head.total,
                        table_overflow: r_overflow,
                        last_entry:     !w_stat.second_valid
                    };
                    if (!w_stat.second_valid) begin
                        n_state    = ccnt_pkg::ST_RUN;
                        n_overflow = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ccnt_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ccnt_pkg::ST_RUN;
            r_phase     <= ccnt_pkg::PH_START;
            r_sym       <= '0;
            r_coeff     <= '0;
            r_digits    <= 1'b0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_sym       <= n_sym;
            r_coeff     <= n_coeff;
            r_digits    <= n_digits;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `ASSERT_NEXT(a_last_goes_final, i_clk, i_rst_n, w_accept && i_data.last_char, r_state == ccnt_pkg::ST_FINAL)
    `ASSERT_SAME(a_drain_nonempty, i_clk, i_rst_n, r_state == ccnt_pkg::ST_DRAIN, w_stat.head.valid)
    `ASSERT_NEXT(a_last_entry_ends, i_clk, i_rst_n, w_load && !w_stat.second_valid, r_state == ccnt_pkg::ST_RUN && !r_overflow)

endmodule

@@ rtl/ccnt_cell.sv @@
// One cell of the sorted symbol table: holds an entry, inserts, accumulates, shifts
`timescale 1ns / 1ps

module ccnt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ccnt_pkg::t_cell_ctl i_ctl,
    input  ccnt_pkg::t_entry    i_prev,
    input  logic                i_prev_gt,
    input  ccnt_pkg::t_entry    i_next,
    output ccnt_pkg::t_entry    o_entry,
    output logic                o_gt,
    output logic                o_match
);

    logic        r_valid;
    logic [15:0] r_sym;
    logic [15:0] r_total;
    logic        n_valid;
    logic [15:0] n_sym;
    logic [15:0] n_total;
    logic [16:0] w_sum;

    assign o_entry = '{valid: r_valid, sym: r_sym, total: r_total};
    assign o_gt    = !r_valid || (r_sym > i_ctl.sym);
    assign o_match = r_valid && (r_sym == i_ctl.sym);
    assign w_sum   = {1'b0, r_total} + {1'b0, i_ctl.add};

    always_comb begin
        n_valid = r_valid;
        n_sym   = r_sym;
        n_total = r_total;
        if (i_ctl.drain) begin
            n_valid = i_next.valid;
            n_sym   = i_next.sym;
            n_total = i_next.total;
        end else if (i_ctl.commit) begin
            if (o_match) begin
                n_total = w_sum[16] ? 16'hFFFF : w_sum[15:0];
            end else if (i_ctl.insert_ok) begin
                if (i_prev_gt) begin
                    n_valid = i_prev.valid;
                    n_sym   = i_prev.sym;
                    n_total = i_prev.total;
                end else if (o_gt) begin
                    n_valid = 1'b1;
                    n_sym   = i_ctl.sym;
                    n_total = i_ctl.add;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym   <= n_sym;
        r_total <= n_total;
    end

endmodule

@@ rtl/ccnt_row.sv @@
// Row of table cells kept in ascending symbol order
`timescale 1ns / 1ps

module ccnt_row (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ccnt_pkg::t_row_ctl  i_ctl,
    output ccnt_pkg::t_row_stat o_stat
);

    localparam int D = ccnt_pkg::TABLE_DEPTH;

    ccnt_pkg::t_entry    w_entry [D];
    logic [D-1:0]        w_gt;
    logic [D-1:0]        w_match;
    ccnt_pkg::t_cell_ctl w_cell_ctl;
    logic                w_any_match;
    logic                w_full;

    assign w_any_match = |w_match;
    assign w_full      = w_entry[D-1].valid;

    assign w_cell_ctl = '{
        commit:    i_ctl.commit,
        insert_ok: i_ctl.commit && !w_any_match && !w_full,
        drain:     i_ctl.drain,
        sym:       i_ctl.sym,
        add:       i_ctl.add
    };

    for (genvar k = 0; k < D; k++) begin : g_cell
        ccnt_pkg::t_entry w_prev;
        ccnt_pkg::t_entry w_next;
        logic             w_prev_gt;

        if (k == 0) begin : g_first
            assign w_prev    = '0;
            assign w_prev_gt = 1'b0;
        end else begin : g_mid
            assign w_prev    = w_entry[k-1];
            assign w_prev_gt = w_gt[k-1];
        end

        if (k == D - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_entry[k+1];
        end

        ccnt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_cell_ctl),
            .i_prev    (w_prev),
            .i_prev_gt (w_prev_gt),
            .i_next    (w_next),
            .o_entry   (w_entry[k]),
            .o_gt      (w_gt[k]),
            .o_match   (w_match[k])
        );
    end

    assign o_stat = '{
        any_match:    w_any_match,
        full:         w_full,
        head:         w_entry[0],
        second_valid: w_entry[1].valid
    };

endmodule
